FILE: src/rlpx_pkg.sv
// ----------------------------------------------------------------------------
// rlpx_pkg: shared types and constants of the run-length palette texel expander
// Holds the item and register codes, the command that passes from the front
// to the back, the back state type and the channel widening function.
// ----------------------------------------------------------------------------
package rlpx_pkg;

   // Largest image that is decoded; a larger pixel_total disables the output.
   localparam int MAX_PIXELS        = 307200;
   // Default palette depth handed to the top level.
   localparam int PALETTE_DEPTH_DEF = 256;
   // Entries in the command queue between front and back.
   localparam int QUEUE_DEPTH       = 4;

   // Field widths fixed by the interface.
   localparam int TOTAL_W = 19;
   localparam int RUN_W   = 5;
   localparam int CSR_IW  = 2;

   // Item operation codes.
   localparam logic OP_PALETTE = 1'b0;
   localparam logic OP_DATA    = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IW-1:0] CSR_RLE_ENABLE       = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_TRANSPARENT_LAST = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_PIXEL_TOTAL      = 2'd2;

   // Register reset values.
   localparam logic [TOTAL_W-1:0] PIXEL_TOTAL_RST = 19'd307200;

   // Stream and palette constants.
   localparam logic [7:0]  RUN_SKIP     = 8'he0;
   localparam logic [31:0] ALPHA_OPAQUE = 32'hff00_0000;
   localparam logic [7:0]  LAST_ENTRY   = 8'd255;

   // Kind of work that the back carries out.
   typedef enum logic {
      CMD_WRITE,
      CMD_PIXEL
   } cmd_kind_type;

   // One queued command: a palette write, or a pixel index with its count.
   typedef struct packed {
      cmd_kind_type     kind;
      logic [7:0]       index;
      logic [31:0]      texel;
      logic [RUN_W-1:0] count;
      logic             oob;
      logic             done;
   } cmd_type;

   // Back sequencer states.
   typedef enum logic {
      BK_IDLE,
      BK_EMIT
   } back_state_type;

   // Widen a 6-bit channel to 8 bits by repeating its top bits.
   function automatic logic [7:0] widen6(input logic [5:0] c);
      return {c, c[5:4]};
   endfunction

endpackage

FILE: src/rle_palette_texel_expander.sv
// ----------------------------------------------------------------------------
// rle_palette_texel_expander: run-length palette texel expander, top level
// Decodes a stream of bitmap bytes into 32-bit texels through a palette.
// ----------------------------------------------------------------------------
// Palette writes (op 0) store a 32-bit texel built from three 6-bit channels
// with opaque alpha, or zero for entry 255 when transparent_last is set; the
// back carries them out and gives no result. Data bytes (op 1) are taken one
// per cycle by the front while the command queue is not full; run codes and
// skip bytes give no result, and a literal or run value becomes a command
// that the back carries out as a palette memory read, then one pixel per
// beat while the output register is free. A four-entry command queue lets
// bytes keep arriving while a run drains, and an output register holds each
// texel until it is popped. Output stops at pixel_total; later data bytes
// are dropped until reset or a raised pixel_total. Palette entries read
// before they are written return undefined data; no clearing pass is run.
module rle_palette_texel_expander import rlpx_pkg::*; #(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // Item channel
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_op,
   input  logic [7:0]         req_pal_index,
   input  logic [5:0]         req_red6,
   input  logic [5:0]         req_green6,
   input  logic [5:0]         req_blue6,
   input  logic [7:0]         req_data_byte,
   // Result channel
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [31:0]        rsp_pixel_rgba,
   output logic               rsp_last_of_run,
   output logic               rsp_image_done,
   // Configuration channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CSR_IW-1:0]  csr_index,
   input  logic [TOTAL_W-1:0] csr_wdata
);

   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_empty;
   cmd_type q_wr_cmd;
   cmd_type q_rd_cmd;

   // Intake and classification.
   rlpx_front #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_op        (req_op),
      .req_pal_index (req_pal_index),
      .req_red6      (req_red6),
      .req_green6    (req_green6),
      .req_blue6     (req_blue6),
      .req_data_byte (req_data_byte),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (q_wr_cmd)
   );

   // Command queue.
   rlpx_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_cmd (q_wr_cmd),
      .full   (q_full),
      .pop    (q_pop),
      .rd_cmd (q_rd_cmd),
      .empty  (q_empty)
   );

   // Palette store and pixel output.
   rlpx_back #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_cmd           (q_rd_cmd),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pixel_rgba  (rsp_pixel_rgba),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_image_done  (rsp_image_done)
   );

endmodule

FILE: src/rlpx_front.sv
// ----------------------------------------------------------------------------
// rlpx_front: item intake and run-length classification
// Holds the configuration registers and the decoder state, accepts items,
// and turns palette writes and pixel runs into commands for the back.
// ----------------------------------------------------------------------------
module rlpx_front import rlpx_pkg::*; #(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // Item channel
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_op,
   input  logic [7:0]         req_pal_index,
   input  logic [5:0]         req_red6,
   input  logic [5:0]         req_green6,
   input  logic [5:0]         req_blue6,
   input  logic [7:0]         req_data_byte,
   // Configuration channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CSR_IW-1:0]  csr_index,
   input  logic [TOTAL_W-1:0] csr_wdata,
   // Command queue
   input  logic               q_full,
   output logic               q_push,
   output cmd_type            q_cmd
);

   logic               rle_enable_ff, rle_enable_in;
   logic               transparent_last_ff, transparent_last_in;
   logic [TOTAL_W-1:0] pixel_total_ff, pixel_total_in;
   logic [TOTAL_W-1:0] emitted_ff, emitted_in;
   logic [RUN_W-1:0]   pending_ff, pending_in;
   logic               await_ff, await_in;

   logic               accept;
   logic               image_ok;
   logic               active;
   logic [TOTAL_W-1:0] remaining;
   logic               run_code;
   logic               emit_req;
   logic [RUN_W-1:0]   emit_count;
   logic [RUN_W-1:0]   emit_n;
   logic               trunc;
   logic               pal_in_range;
   logic [31:0]        pal_texel;

   assign accept    = req_push && !q_full;
   assign req_full  = q_full;
   assign csr_ready = 1'b1;

   // Image limits and the pixels still owed to the image.
   assign image_ok  = (pixel_total_ff != '0)
                      && ({2'b00, pixel_total_ff} <= 21'(MAX_PIXELS));
   assign active    = image_ok && (emitted_ff < pixel_total_ff);
   assign remaining = pixel_total_ff - emitted_ff;

   // Classify a data byte: run value, run code or literal pixel.
   assign run_code = rle_enable_ff && (req_data_byte >= RUN_SKIP);

   always_comb begin
      emit_req   = 1'b0;
      emit_count = '0;
      if (await_ff) begin
         emit_req   = 1'b1;
         emit_count = pending_ff;
      end else if (!run_code) begin
         emit_req   = 1'b1;
         emit_count = RUN_W'(1);
      end
   end

   // Clip the run at the end of the image.
   assign trunc  = {{(TOTAL_W-RUN_W){1'b0}}, emit_count} >= remaining;
   assign emit_n = trunc ? remaining[RUN_W-1:0] : emit_count;

   // Palette entry as it is stored.
   assign pal_in_range = {1'b0, req_pal_index} < 9'(PALETTE_DEPTH);
   always_comb begin
      pal_texel = ALPHA_OPAQUE
                  | {8'h00, widen6(req_blue6), widen6(req_green6), widen6(req_red6)};
      if (transparent_last_ff && (req_pal_index == LAST_ENTRY)) begin
         pal_texel = '0;
      end
   end

   // Command toward the back.
   always_comb begin
      q_push       = 1'b0;
      q_cmd.kind   = CMD_PIXEL;
      q_cmd.index  = req_data_byte;
      q_cmd.texel  = pal_texel;
      q_cmd.count  = emit_n;
      q_cmd.oob    = {1'b0, req_data_byte} >= 9'(PALETTE_DEPTH);
      q_cmd.done   = trunc;
      if (req_op == OP_PALETTE) begin
         q_cmd.kind  = CMD_WRITE;
         q_cmd.index = req_pal_index;
         q_push      = accept && pal_in_range;
      end else begin
         q_push      = accept && active && emit_req;
      end
   end

   // Decoder state update.
   always_comb begin
      emitted_in = emitted_ff;
      pending_in = pending_ff;
      await_in   = await_ff;
      if (accept && (req_op == OP_DATA) && active) begin
         if (await_ff) begin
            await_in   = 1'b0;
            pending_in = '0;
         end else if (run_code && (req_data_byte != RUN_SKIP)) begin
            await_in   = 1'b1;
            pending_in = req_data_byte[RUN_W-1:0];
         end
         if (emit_req) begin
            emitted_in = emitted_ff + TOTAL_W'(emit_n);
         end
      end
   end

   // Configuration register writes.
   always_comb begin
      rle_enable_in       = rle_enable_ff;
      transparent_last_in = transparent_last_ff;
      pixel_total_in      = pixel_total_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RLE_ENABLE:       rle_enable_in       = csr_wdata[0];
            CSR_TRANSPARENT_LAST: transparent_last_in = csr_wdata[0];
            CSR_PIXEL_TOTAL:      pixel_total_in      = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rle_enable_ff       <= 1'b1;
         transparent_last_ff <= 1'b1;
         pixel_total_ff      <= PIXEL_TOTAL_RST;
         emitted_ff          <= '0;
         pending_ff          <= '0;
         await_ff            <= 1'b0;
      end else begin
         rle_enable_ff       <= rle_enable_in;
         transparent_last_ff <= transparent_last_in;
         pixel_total_ff      <= pixel_total_in;
         emitted_ff          <= emitted_in;
         pending_ff          <= pending_in;
         await_ff            <= await_in;
      end
   end

`ifndef SYNTHESIS
   // A pending run always has a length of at least one.
   a_await_len: assert property (@(posedge clock) disable iff (reset)
      await_ff |-> (pending_ff != '0))
      else $error("run pending with zero length");

   // Every pixel command carries at least one pixel.
   a_pixel_count: assert property (@(posedge clock) disable iff (reset)
      (q_push && (q_cmd.kind == CMD_PIXEL)) |-> (q_cmd.count != '0))
      else $error("pixel command with zero count");

   // A run code or a skip byte starts no command and leaves the count alone.
   a_code_quiet: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == OP_DATA) && !await_ff && run_code)
      |-> (!q_push && (emitted_in == emitted_ff)))
      else $error("run code produced pixels");
`endif

endmodule

FILE: src/rlpx_queue.sv
// ----------------------------------------------------------------------------
// rlpx_queue: command queue between front and back
// A short first-in first-out store of commands so that item intake and
// pixel output stall independently.
// ----------------------------------------------------------------------------
module rlpx_queue import rlpx_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type wr_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type rd_cmd,
   output logic    empty
);

   localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entries_ff [QUEUE_DEPTH];
   logic [QPW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   count_ff, count_in;

   assign full   = (count_ff == QCW'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign rd_cmd = entries_ff[rd_ptr_ff];

   // Pointer and fill updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

`ifndef SYNTHESIS
   // The front never writes into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   // The back never reads an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

   // The fill count stays within the storage.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCW'(QUEUE_DEPTH))
      else $error("queue fill count out of range");
`endif

endmodule

FILE: src/rlpx_back.sv
// ----------------------------------------------------------------------------
// rlpx_back: palette store and pixel emitter
// Carries out queued commands: writes palette entries, looks up pixel
// indexes and sends out one texel per beat through an output register.
// ----------------------------------------------------------------------------
module rlpx_back import rlpx_pkg::*; #(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Command queue
   input  logic        q_empty,
   input  cmd_type     q_cmd,
   output logic        q_pop,
   // Result channel
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_pixel_rgba,
   output logic        rsp_last_of_run,
   output logic        rsp_image_done
);

   localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

   logic [31:0]       palette_mem [PALETTE_DEPTH];

   back_state_type    state_ff, state_in;
   logic [RUN_W-1:0]  count_ff, count_in;
   logic              oob_ff, oob_in;
   logic              done_ff, done_in;
   logic [31:0]       rdata_ff;

   logic              out_valid_ff, out_valid_in;
   logic [31:0]       out_rgba_ff;
   logic              out_last_ff;
   logic              out_done_ff;

   logic              slot_free;
   logic              load_out;
   logic              mem_we;
   logic              mem_re;
   logic              last_beat;
   logic [PAL_AW-1:0] addr;

   assign slot_free = !out_valid_ff || rsp_pop;
   assign last_beat = (count_ff == RUN_W'(1));
   assign addr      = q_cmd.index[PAL_AW-1:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty && (q_cmd.kind == CMD_PIXEL)) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (slot_free && last_beat) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      q_pop    = 1'b0;
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            q_pop  = !q_empty;
            mem_we = !q_empty && (q_cmd.kind == CMD_WRITE);
            mem_re = !q_empty && (q_cmd.kind == CMD_PIXEL);
         end
         BK_EMIT: begin
            load_out = slot_free;
         end
         default: ;
      endcase
   end

   // Run bookkeeping.
   always_comb begin
      count_in = count_ff;
      oob_in   = oob_ff;
      done_in  = done_ff;
      if (mem_re) begin
         count_in = q_cmd.count;
         oob_in   = q_cmd.oob;
         done_in  = q_cmd.done;
      end else if (load_out) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Output register valid.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      oob_ff  <= oob_in;
      done_ff <= done_in;
   end

   // Palette memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         palette_mem[addr] <= q_cmd.texel;
      end
      if (mem_re) begin
         rdata_ff <= palette_mem[addr];
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (load_out) begin
         out_rgba_ff <= oob_ff ? 32'h0000_0000 : rdata_ff;
         out_last_ff <= last_beat;
         out_done_ff <= last_beat && done_ff;
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_pixel_rgba  = out_rgba_ff;
   assign rsp_last_of_run = out_last_ff;
   assign rsp_image_done  = out_done_ff;

`ifndef SYNTHESIS
   // A run in progress always has beats left.
   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_EMIT) |-> (count_ff != '0))
      else $error("emitting with no beats left");

   // A waiting result is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!out_valid_ff || rsp_pop))
      else $error("result overwritten before taken");

   // The image completion flag only marks the last beat of a run.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_done_ff) |-> out_last_ff)
      else $error("image done away from last beat");

   // The memory is never written and read in the same cycle.
   a_one_port: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("palette write and read together");
`endif

endmodule
